@@ src/uri_path_canonicalizer_defines.svh @@
// assertion helpers for the path canonicalizer
`ifndef URI_PATH_CANONICALIZER_DEFINES_SVH
`define URI_PATH_CANONICALIZER_DEFINES_SVH

// same-cycle implication under the async reset
`define UPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uri path canonicalizer: check failed");

// next-cycle implication under the async reset
`define UPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uri path canonicalizer: check failed");

`endif

@@ src/upc_pkg.sv @@
package upc_pkg;

	localparam int MAX_PATH    = 256;
	localparam int MAX_DEPTH   = 32;
	localparam int MAX_RESULTS = 3;
	localparam int FIFO_DEPTH  = 8;

	localparam int LEN_W   = $clog2(MAX_PATH + 1);
	localparam int POS_W   = $clog2(MAX_PATH);
	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W   = $clog2(MAX_DEPTH);
	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOSLASH = 3'd1;
	localparam logic [2:0] ST_BADHEX  = 3'd2;
	localparam logic [2:0] ST_TRUNC   = 3'd3;
	localparam logic [2:0] ST_NULL    = 3'd4;
	localparam logic [2:0] ST_CTRL    = 3'd5;
	localparam logic [2:0] ST_DEL     = 3'd6;
	localparam logic [2:0] ST_OVF     = 3'd7;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	localparam logic [0:0] KIND_WRITE   = 1'b0;
	localparam logic [0:0] KIND_SUMMARY = 1'b1;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_DEL     = 8'd127;
	localparam logic [7:0] CH_SPACE   = 8'd32;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       end_of_path;
	} item_t;

	typedef struct packed {
		logic [0:0] result_kind;
		logic [7:0] write_position;
		logic [7:0] write_byte;
		logic [8:0] path_length;
		logic [2:0] status;
		logic       run_last;
	} result_t;

	// decode errors outrank a missing slash, which outranks overflow
	function automatic logic [1:0] err_rank(input logic [2:0] code);
		logic [1:0] r;
		case (code)
			ST_BADHEX, ST_TRUNC, ST_NULL, ST_CTRL, ST_DEL: r = 2'd3;
			ST_NOSLASH: r = 2'd2;
			ST_OVF:     r = 2'd1;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] raise_err(input logic [2:0] cur, input logic [2:0] code);
		return (err_rank(code) > err_rank(cur)) ? code : cur;
	endfunction

	// msb set when the byte is a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] h;
		if (c inside {[8'h30:8'h39]}) h = {1'b1, 4'(c - 8'h30)};
		else if (c inside {[8'h41:8'h46]}) h = {1'b1, 4'(c - 8'h37)};
		else if (c inside {[8'h61:8'h66]}) h = {1'b1, 4'(c - 8'h57)};
		else h = 5'd0;
		return h;
	endfunction

	function automatic result_t make_write(input logic [POS_W-1:0] pos, input logic [7:0] b);
		result_t r;
		r.result_kind    = KIND_WRITE;
		r.write_position = 8'(pos);
		r.write_byte     = b;
		r.path_length    = 9'd0;
		r.status         = ST_OK;
		r.run_last       = 1'b0;
		return r;
	endfunction

endpackage

@@ src/uri_path_canonicalizer.sv @@
// Percent-decodes a request path one byte per request and removes empty, "." and ".."
// segments, emitting byte writes into the canonical path and one summary (length, status)
// after the byte marked end_of_path, after which the block is back in its reset state.
// A request is registered on acceptance and processed from that register, so a request
// can be taken every cycle while the queue has room; its results (up to three) enter an
// eight-entry queue and leave at one per cycle while result_stall is low. A request is held
// while the queue has fewer than three free entries, so the sustained rate is one request
// per cycle while each causes at most one result, and otherwise one result per cycle on
// the output side. Segment start positions sit in a 32 by 8 memory whose top entry is read
// ahead into a register; it needs no clearing after reset.
`include "uri_path_canonicalizer_defines.svh"

module uri_path_canonicalizer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  upc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output upc_pkg::result_t result
);

	// request stage
	logic           valid_s1;
	upc_pkg::item_t item_s1;

	// path state
	logic [1:0]                  esc_q;
	logic [3:0]                  hn_q;
	logic [2:0]                  err_q;
	logic                        seen_q;
	logic [upc_pkg::LEN_W-1:0]   olen_q;
	logic [upc_pkg::DEPTH_W-1:0] depth_q;
	logic [upc_pkg::POS_W-1:0]   cstart_q;
	logic [upc_pkg::LEN_W-1:0]   clen_q;
	logic [1:0]                  dots_q;

	// segment start stack
	logic [upc_pkg::POS_W-1:0] seg_mem [upc_pkg::MAX_DEPTH];
	logic [upc_pkg::POS_W-1:0] top_q;
	logic [upc_pkg::DEPTH_W-1:0] rd_depth;
	logic [upc_pkg::DEPTH_W-1:0] rd_dec;
	logic [upc_pkg::IDX_W-1:0]   raddr;

	// result queue
	upc_pkg::result_t          res_q [upc_pkg::FIFO_DEPTH];
	logic [upc_pkg::PTR_W-1:0] wr_ptr_q;
	logic [upc_pkg::PTR_W-1:0] rd_ptr_q;
	logic [upc_pkg::CNT_W-1:0] count_q;
	logic                      room;
	logic                      fire;
	logic                      pop;
	logic [1:0]                push_n;
	logic [upc_pkg::PTR_W-1:0] widx [upc_pkg::MAX_RESULTS];

	// next-state values
	logic [1:0]                  esc_v;
	logic [3:0]                  hn_v;
	logic [2:0]                  err_v;
	logic                        seen_v;
	logic [upc_pkg::LEN_W-1:0]   olen_v;
	logic [upc_pkg::DEPTH_W-1:0] depth_v;
	logic [upc_pkg::POS_W-1:0]   cstart_v;
	logic [upc_pkg::LEN_W-1:0]   clen_v;
	logic [1:0]                  dots_v;
	logic [1:0]                  n_v;
	upc_pkg::result_t            res_v [upc_pkg::MAX_RESULTS];
	logic                        we_v;
	logic [upc_pkg::IDX_W-1:0]   waddr_v;
	logic [upc_pkg::POS_W-1:0]   wdata_v;
	logic                        do_byte;
	logic [7:0]                  bc;
	logic                        close_sl;
	logic                        ok;
	logic [4:0]                  hx;
	logic [7:0]                  dec;
	logic [2:0]                  st;

	assign room       = count_q <= upc_pkg::CNT_W'(upc_pkg::FIFO_DEPTH - upc_pkg::MAX_RESULTS);
	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		esc_v    = esc_q;
		hn_v     = hn_q;
		err_v    = err_q;
		seen_v   = seen_q;
		olen_v   = olen_q;
		depth_v  = depth_q;
		cstart_v = cstart_q;
		clen_v   = clen_q;
		dots_v   = dots_q;
		n_v      = 2'd0;
		for (int k = 0; k < upc_pkg::MAX_RESULTS; k++) begin
			res_v[k] = '0;
		end
		we_v     = 1'b0;
		waddr_v  = '0;
		wdata_v  = '0;
		do_byte  = 1'b0;
		bc       = item_s1.path_byte;
		close_sl = 1'b0;
		ok       = 1'b1;
		hx       = upc_pkg::hex_value(item_s1.path_byte);
		dec      = {hn_q, hx[3:0]};
		st       = upc_pkg::ST_OK;

		// percent decoding
		if (upc_pkg::err_rank(err_v) < 2'd3) begin
			case (esc_q)
				upc_pkg::ESC_NONE: begin
					if (item_s1.path_byte == upc_pkg::CH_PERCENT) begin
						if (item_s1.end_of_path) err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_TRUNC);
						else esc_v = upc_pkg::ESC_HIGH;
					end else begin
						do_byte = 1'b1;
					end
				end
				upc_pkg::ESC_HIGH: begin
					esc_v = upc_pkg::ESC_NONE;
					if (item_s1.end_of_path) begin
						err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_TRUNC);
					end else if (!hx[4]) begin
						err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_BADHEX);
					end else begin
						hn_v  = hx[3:0];
						esc_v = upc_pkg::ESC_LOW;
					end
				end
				default: begin
					esc_v = upc_pkg::ESC_NONE;
					if (!hx[4]) err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_BADHEX);
					else if (dec == 8'd0) err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_NULL);
					else if (dec < upc_pkg::CH_SPACE) err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_CTRL);
					else if (dec == upc_pkg::CH_DEL) err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_DEL);
					else begin
						do_byte = 1'b1;
						bc      = dec;
					end
				end
			endcase
		end

		// decoded byte into the segment logic
		if (do_byte) begin
			if (!seen_v) begin
				seen_v = 1'b1;
				if (bc != upc_pkg::CH_SLASH) begin
					err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_NOSLASH);
				end else if (olen_v >= upc_pkg::LEN_W'(upc_pkg::MAX_PATH)) begin
					err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_OVF);
				end else begin
					res_v[n_v] = upc_pkg::make_write(olen_v[upc_pkg::POS_W-1:0], upc_pkg::CH_SLASH);
					n_v        = n_v + 2'd1;
					olen_v     = olen_v + upc_pkg::LEN_W'(1);
					clen_v     = '0;
					dots_v     = 2'd0;
				end
			end else if (err_v == upc_pkg::ST_OK) begin
				if (bc == upc_pkg::CH_SLASH) begin
					close_sl = 1'b1;
				end else begin
					if (clen_v == '0) begin
						cstart_v = olen_v[upc_pkg::POS_W-1:0];
						if (depth_v != '0) begin
							// separator ahead of every segment but the first
							if (olen_v >= upc_pkg::LEN_W'(upc_pkg::MAX_PATH)) begin
								err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_OVF);
								ok    = 1'b0;
							end else begin
								res_v[n_v] = upc_pkg::make_write(olen_v[upc_pkg::POS_W-1:0],
									upc_pkg::CH_SLASH);
								n_v        = n_v + 2'd1;
								olen_v     = olen_v + upc_pkg::LEN_W'(1);
							end
						end
					end
					if (ok) begin
						if (olen_v >= upc_pkg::LEN_W'(upc_pkg::MAX_PATH)) begin
							err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_OVF);
						end else begin
							res_v[n_v] = upc_pkg::make_write(olen_v[upc_pkg::POS_W-1:0], bc);
							n_v        = n_v + 2'd1;
							olen_v     = olen_v + upc_pkg::LEN_W'(1);
							clen_v     = clen_v + upc_pkg::LEN_W'(1);
							if (dots_v != 2'd3) begin
								if (bc == upc_pkg::CH_DOT && dots_v < 2'd2) dots_v = dots_v + 2'd1;
								else dots_v = 2'd3;
							end
						end
					end
				end
			end
		end

		// segment close on a slash, then again at end of path
		for (int k = 0; k < 2; k++) begin
			if ((k == 0 && close_sl) || (k == 1 && item_s1.end_of_path)) begin
				if (err_v == upc_pkg::ST_OK && clen_v != '0) begin
					if (dots_v == 2'd1) begin
						olen_v = upc_pkg::LEN_W'(cstart_v);
					end else if (dots_v == 2'd2) begin
						olen_v = upc_pkg::LEN_W'(cstart_v);
						if (depth_v != '0) begin
							depth_v = depth_v - upc_pkg::DEPTH_W'(1);
							olen_v  = upc_pkg::LEN_W'(top_q);
						end
					end else if (depth_v >= upc_pkg::DEPTH_W'(upc_pkg::MAX_DEPTH)) begin
						err_v = upc_pkg::raise_err(err_v, upc_pkg::ST_OVF);
					end else begin
						we_v    = 1'b1;
						waddr_v = depth_v[upc_pkg::IDX_W-1:0];
						wdata_v = cstart_v;
						depth_v = depth_v + upc_pkg::DEPTH_W'(1);
					end
				end
				clen_v = '0;
				dots_v = 2'd0;
			end
		end

		if (item_s1.end_of_path) begin
			st = err_v;
			if (st == upc_pkg::ST_OK && !seen_v) st = upc_pkg::ST_NOSLASH;
			res_v[n_v].result_kind = upc_pkg::KIND_SUMMARY;
			res_v[n_v].status      = st;
			res_v[n_v].path_length = (st == upc_pkg::ST_OK) ? 9'(olen_v) : 9'd0;
			n_v      = n_v + 2'd1;
			esc_v    = upc_pkg::ESC_NONE;
			hn_v     = '0;
			err_v    = upc_pkg::ST_OK;
			seen_v   = 1'b0;
			olen_v   = '0;
			depth_v  = '0;
			cstart_v = '0;
			clen_v   = '0;
			dots_v   = 2'd0;
		end

		if (n_v != 2'd0) begin
			res_v[n_v - 2'd1].run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= upc_pkg::ESC_NONE;
			hn_q     <= '0;
			err_q    <= upc_pkg::ST_OK;
			seen_q   <= 1'b0;
			olen_q   <= '0;
			depth_q  <= '0;
			cstart_q <= '0;
			clen_q   <= '0;
			dots_q   <= 2'd0;
		end else if (fire) begin
			esc_q    <= esc_v;
			hn_q     <= hn_v;
			err_q    <= err_v;
			seen_q   <= seen_v;
			olen_q   <= olen_v;
			depth_q  <= depth_v;
			cstart_q <= cstart_v;
			clen_q   <= clen_v;
			dots_q   <= dots_v;
		end
	end

	// keep the entry below the next depth in top_q, forwarding a same-cycle push
	assign rd_depth = fire ? depth_v : depth_q;
	assign rd_dec   = rd_depth - upc_pkg::DEPTH_W'(1);
	assign raddr    = rd_dec[upc_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (fire && we_v) begin
			seg_mem[waddr_v] <= wdata_v;
		end
		if (fire && we_v && waddr_v == raddr) begin
			top_q <= wdata_v;
		end else begin
			top_q <= seg_mem[raddr];
		end
	end

	// result queue
	assign push_n       = fire ? n_v : 2'd0;
	assign pop          = result_valid && !result_stall;
	assign result_valid = count_q != '0;
	assign result       = res_q[rd_ptr_q];

	always_comb begin
		for (int k = 0; k < upc_pkg::MAX_RESULTS; k++) begin
			widx[k] = wr_ptr_q + upc_pkg::PTR_W'(k);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < upc_pkg::MAX_RESULTS; k++) begin
			if (2'(k) < push_n) begin
				res_q[widx[k]] <= res_v[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + upc_pkg::PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + upc_pkg::PTR_W'(pop);
			count_q  <= count_q + upc_pkg::CNT_W'(push_n) - upc_pkg::CNT_W'(pop);
		end
	end

	`UPC_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, count_q <= upc_pkg::CNT_W'(upc_pkg::FIFO_DEPTH))
	`UPC_ASSERT_NOW(a_depth_bound, clk, arst_n, 1'b1, depth_q <= upc_pkg::DEPTH_W'(upc_pkg::MAX_DEPTH))
	`UPC_ASSERT_NEXT(a_path_restart, clk, arst_n, fire && item_s1.end_of_path, olen_q == '0 && depth_q == '0 && !seen_q)
	`UPC_ASSERT_NEXT(a_stage_hold, clk, arst_n, valid_s1 && !fire, valid_s1 && $stable(item_s1))

endmodule

@@ test/tb.sv @@
module tb;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	upc_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	upc_pkg::result_t result;

	uri_path_canonicalizer DUT (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	int err_cnt = 0;
	int req_cnt = 0;
	int path_cnt = 0;
	int checked_cnt = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	// expected byte writes and summaries, oldest first
	upc_pkg::result_t canon_q[$];
	upc_pkg::result_t held;
	bit               have_held;

	// shadow of the canonicalizer state
	logic [1:0] esc;
	logic [3:0] hi_nib;
	logic [2:0] err_code;
	bit         seen_first;
	int         out_len;
	int         seg_starts [upc_pkg::MAX_DEPTH];
	int         depth;
	int         seg_begin;
	int         seg_len;
	int         dot_run;

	logic [7:0] raw_path[$];

	typedef struct packed {
		logic [7:0] b;
		logic       eop;
		logic       literal_exp;
		logic [2:0] st;
		logic [8:0] len;
	} dir_row_t;

	// rows with literal_exp set carry the summary typed in by hand
	dir_row_t dir_rows [25] = '{
		'{upc_pkg::CH_SLASH,   1'b1, 1'b1, upc_pkg::ST_OK,      9'd1},
		'{upc_pkg::CH_PERCENT, 1'b1, 1'b1, upc_pkg::ST_TRUNC,   9'd0},
		'{"a",                 1'b1, 1'b1, upc_pkg::ST_NOSLASH, 9'd0},
		'{upc_pkg::CH_PERCENT, 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"2",                 1'b1, 1'b1, upc_pkg::ST_TRUNC,   9'd0},
		'{upc_pkg::CH_SLASH,   1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{upc_pkg::CH_PERCENT, 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"G",                 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"x",                 1'b1, 1'b1, upc_pkg::ST_BADHEX,  9'd0},
		'{upc_pkg::CH_PERCENT, 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"0",                 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"0",                 1'b1, 1'b1, upc_pkg::ST_NULL,    9'd0},
		'{upc_pkg::CH_PERCENT, 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"1",                 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"f",                 1'b1, 1'b1, upc_pkg::ST_CTRL,    9'd0},
		'{upc_pkg::CH_PERCENT, 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"7",                 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"F",                 1'b1, 1'b1, upc_pkg::ST_DEL,     9'd0},
		'{upc_pkg::CH_SLASH,   1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{8'hff,               1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{8'h00,               1'b1, 1'b1, upc_pkg::ST_OK,      9'd3},
		'{upc_pkg::CH_PERCENT, 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"2",                 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{"F",                 1'b0, 1'b0, upc_pkg::ST_OK,      9'd0},
		'{upc_pkg::CH_DOT,     1'b1, 1'b0, upc_pkg::ST_OK,      9'd0}
	};

	function automatic void expect_result(input upc_pkg::result_t r);
		canon_q.insert(canon_q.size(), r);
	endfunction

	function automatic void append_raw(input logic [7:0] c);
		raw_path.insert(raw_path.size(), c);
	endfunction

	function automatic int rank_of(input logic [2:0] code);
		if (code >= upc_pkg::ST_BADHEX && code <= upc_pkg::ST_DEL) return 3;
		if (code == upc_pkg::ST_NOSLASH) return 2;
		if (code == upc_pkg::ST_OVF) return 1;
		return 0;
	endfunction

	function automatic void note_error(input logic [2:0] code);
		if (rank_of(code) > rank_of(err_code)) err_code = code;
	endfunction

	function automatic void clear_state();
		esc = upc_pkg::ESC_NONE;
		hi_nib = '0;
		err_code = upc_pkg::ST_OK;
		seen_first = 1'b0;
		out_len = 0;
		depth = 0;
		seg_begin = 0;
		seg_len = 0;
		dot_run = 0;
	endfunction

	// the last result of a request gets run_last, so each one is held back by one
	function automatic void queue_result(input logic [0:0] kind, input int pos,
			input logic [7:0] b, input int len, input logic [2:0] st);
		upc_pkg::result_t r;
		if (have_held) expect_result(held);
		r.result_kind = kind;
		r.write_position = 8'(pos);
		r.write_byte = b;
		r.path_length = 9'(len);
		r.status = st;
		r.run_last = 1'b0;
		held = r;
		have_held = 1'b1;
	endfunction

	function automatic bit put_out(input logic [7:0] c);
		if (out_len >= upc_pkg::MAX_PATH) begin
			note_error(upc_pkg::ST_OVF);
			return 1'b0;
		end
		queue_result(upc_pkg::KIND_WRITE, out_len, c, 0, upc_pkg::ST_OK);
		out_len++;
		return 1'b1;
	endfunction

	// "." rewinds to the segment start, ".." also pops the previous segment
	function automatic void close_seg();
		if (err_code != upc_pkg::ST_OK || seg_len == 0) begin
			seg_len = 0;
			dot_run = 0;
			return;
		end
		if (dot_run == 1) begin
			out_len = seg_begin;
		end else if (dot_run == 2) begin
			out_len = seg_begin;
			if (depth > 0) begin
				depth--;
				out_len = seg_starts[depth];
			end
		end else if (depth >= upc_pkg::MAX_DEPTH) begin
			note_error(upc_pkg::ST_OVF);
		end else begin
			seg_starts[depth] = seg_begin;
			depth++;
		end
		seg_len = 0;
		dot_run = 0;
	endfunction

	function automatic void take_char(input logic [7:0] c);
		if (!seen_first) begin
			seen_first = 1'b1;
			if (c != upc_pkg::CH_SLASH) begin
				note_error(upc_pkg::ST_NOSLASH);
				return;
			end
			if (put_out(upc_pkg::CH_SLASH)) begin
				seg_len = 0;
				dot_run = 0;
			end
			return;
		end
		if (err_code != upc_pkg::ST_OK) return;
		if (c == upc_pkg::CH_SLASH) begin
			close_seg();
			return;
		end
		if (seg_len == 0) begin
			seg_begin = out_len;
			if (depth > 0 && !put_out(upc_pkg::CH_SLASH)) return;
		end
		if (!put_out(c)) return;
		seg_len++;
		if (dot_run != 3) begin
			if (c == upc_pkg::CH_DOT && dot_run < 2) dot_run++;
			else dot_run = 3;
		end
	endfunction

	function automatic int hex_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	function automatic void canonicalize(input upc_pkg::item_t it);
		logic [7:0] c;
		bit         is_last;
		int         h;
		logic [7:0] v;
		logic [2:0] st;
		c = it.path_byte;
		is_last = it.end_of_path;
		if (rank_of(err_code) < 3) begin
			if (esc == upc_pkg::ESC_NONE) begin
				if (c == upc_pkg::CH_PERCENT) begin
					if (is_last) note_error(upc_pkg::ST_TRUNC);
					else esc = upc_pkg::ESC_HIGH;
				end else begin
					take_char(c);
				end
			end else if (esc == upc_pkg::ESC_HIGH) begin
				h = hex_of(c);
				esc = upc_pkg::ESC_NONE;
				if (is_last) note_error(upc_pkg::ST_TRUNC);
				else if (h < 0) note_error(upc_pkg::ST_BADHEX);
				else begin
					hi_nib = h[3:0];
					esc = upc_pkg::ESC_LOW;
				end
			end else begin
				h = hex_of(c);
				esc = upc_pkg::ESC_NONE;
				if (h < 0) begin
					note_error(upc_pkg::ST_BADHEX);
				end else begin
					v = {hi_nib, h[3:0]};
					if (v == 8'd0) note_error(upc_pkg::ST_NULL);
					else if (v < upc_pkg::CH_SPACE) note_error(upc_pkg::ST_CTRL);
					else if (v == upc_pkg::CH_DEL) note_error(upc_pkg::ST_DEL);
					else take_char(v);
				end
			end
		end
		if (is_last) begin
			close_seg();
			st = err_code;
			if (st == upc_pkg::ST_OK && !seen_first) st = upc_pkg::ST_NOSLASH;
			queue_result(upc_pkg::KIND_SUMMARY, 0, 8'd0,
				(st == upc_pkg::ST_OK) ? out_len : 0, st);
			clear_state();
		end
		if (have_held) begin
			held.run_last = 1'b1;
			expect_result(held);
			have_held = 1'b0;
		end
	endfunction

	// path generation
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0" + n);
		return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
	endfunction

	function automatic void add_esc(input logic [7:0] v);
		append_raw(upc_pkg::CH_PERCENT);
		append_raw(hex_char(v[7:4]));
		append_raw(hex_char(v[3:0]));
	endfunction

	function automatic void add_char(input logic [7:0] c);
		if (c == upc_pkg::CH_PERCENT || (c >= upc_pkg::CH_SPACE && c != upc_pkg::CH_DEL &&
				$urandom_range(3) == 0))
			add_esc(c);
		else
			append_raw(c);
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		case ($urandom_range(4))
			0, 1: c = 8'("a" + $urandom_range(25));
			2: c = 8'("0" + $urandom_range(9));
			3: c = upc_pkg::CH_DOT;
			default: c = 8'($urandom_range(255));
		endcase
		if (c == upc_pkg::CH_SLASH) c = "_";
		return c;
	endfunction

	function automatic void add_sep();
		if ($urandom_range(7) == 0) add_esc(upc_pkg::CH_SLASH);
		else append_raw(upc_pkg::CH_SLASH);
	endfunction

	function automatic void add_segment();
		case ($urandom_range(9))
			0: ;
			1: add_char(upc_pkg::CH_DOT);
			2, 3: begin
				add_char(upc_pkg::CH_DOT);
				add_char(upc_pkg::CH_DOT);
			end
			default: repeat ($urandom_range(1, 4)) add_char(name_char());
		endcase
	endfunction

	function automatic void make_random_path();
		int n;
		int kind;
		raw_path.delete();
		kind = $urandom_range(99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 8)) append_raw(8'($urandom_range(255)));
			return;
		end
		add_sep();
		n = $urandom_range(0, 8);
		for (int i = 0; i < n; i++) begin
			if (i > 0) add_sep();
			add_segment();
		end
		if ($urandom_range(4) == 0) add_sep();
		if (kind < 75) return;
		// broken variants of a well-formed path
		case ($urandom_range(5))
			0: raw_path[0] = name_char();
			1: begin
				append_raw(upc_pkg::CH_PERCENT);
				if ($urandom_range(1)) append_raw(hex_char(4'($urandom_range(15))));
				append_raw(8'("z" - $urandom_range(3)));
				append_raw("x");
			end
			2: begin
				add_esc(8'($urandom_range(31)));
				add_sep();
				add_segment();
			end
			3: begin
				add_esc(upc_pkg::CH_DEL);
				add_segment();
			end
			4: append_raw(upc_pkg::CH_PERCENT);
			default: begin
				append_raw(upc_pkg::CH_PERCENT);
				append_raw(hex_char(4'($urandom_range(15))));
			end
		endcase
	endfunction

	// more segments than the depth limit allows
	function automatic void make_deep_path();
		raw_path.delete();
		append_raw(upc_pkg::CH_SLASH);
		repeat (upc_pkg::MAX_DEPTH + 1) begin
			append_raw(8'("a" + $urandom_range(25)));
			append_raw(upc_pkg::CH_SLASH);
		end
	endfunction

	task automatic send_item(input upc_pkg::item_t it);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		canonicalize(it);
		req_cnt++;
	endtask

	task automatic send_path();
		upc_pkg::item_t it;
		for (int i = 0; i < raw_path.size(); i++) begin
			it.path_byte = raw_path[i];
			it.end_of_path = (i == raw_path.size() - 1);
			send_item(it);
		end
		path_cnt++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (canon_q.size() != 0);
	endtask

	task automatic random_paths(input int n_req);
		int target;
		target = req_cnt + n_req;
		while (req_cnt < target) begin
			make_random_path();
			send_path();
		end
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 60;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			err_cnt++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		upc_pkg::result_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (canon_q.size() == 0) begin
				$error("result with nothing expected: kind %0d pos %0d byte 0x%0h status %0d",
					result.result_kind, result.write_position, result.write_byte,
					result.status);
				err_cnt++;
			end else begin
				w = canon_q.pop_front();
				check_field("result_kind", w.result_kind, result.result_kind);
				check_field("write_position", w.write_position, result.write_position);
				check_field("write_byte", w.write_byte, result.write_byte);
				check_field("path_length", w.path_length, result.path_length);
				check_field("status", w.status, result.status);
				check_field("run_last", w.run_last, result.run_last);
				checked_cnt++;
			end
		end
	end

	initial begin
		upc_pkg::item_t it;
		clear_state();
		have_held = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			it.path_byte = dir_rows[k].b;
			it.end_of_path = dir_rows[k].eop;
			send_item(it);
			if (dir_rows[k].literal_exp)
				canon_q[canon_q.size() - 1] = upc_pkg::result_t'{upc_pkg::KIND_SUMMARY,
					8'd0, 8'd0, dir_rows[k].len, dir_rows[k].st, 1'b1};
		end
		drain_results();

		send_idle_pct = 8;
		recv_idle_pct = 58;
		random_paths(10);
		drain_results();

		send_idle_pct = 58;
		recv_idle_pct = 8;
		random_paths(10);
		drain_results();

		// receiver holds off while a deep path streams in, so the request side stalls
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		make_deep_path();
		send_path();
		drain_results();
		repeat (20) @(posedge clk);

		$display("%0d paths in %0d requests, %0d results checked", path_cnt, req_cnt,
			checked_cnt);
		$display("covered escapes, dot segments, decode errors and depth overflow under backpressure");
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3200000;
		$error("timeout with %0d results outstanding", canon_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
